// ----- src/triangle_tangent_bitangent_assert.svh -----
// assertion macros for the tangent/bitangent block
`ifndef TRIANGLE_TANGENT_BITANGENT_ASSERT_SVH
`define TRIANGLE_TANGENT_BITANGENT_ASSERT_SVH

// same-cycle implication
`define TBT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tbt check failed");

// next-cycle implication
`define TBT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tbt check failed");

`endif

// ----- src/tbt_pkg.sv -----
`default_nettype none
package tbt_pkg;
    localparam int FRAC_BITS = 16;
    localparam int DW = 33;          // edge delta width
    localparam int PW = 66;          // product width
    localparam int CW = 67;          // cross term width
    localparam int MW = 66;          // cross magnitude width
    localparam int NW = MW + FRAC_BITS;
    localparam int QW = 32;
    localparam int CMPW = MW + QW;
    localparam int NCROSS = 7;
    localparam int NSTEP = 2 * NCROSS;

    typedef struct packed {
        logic [2:0][DW-1:0] dp1;
        logic [2:0][DW-1:0] dp2;
        logic [DW-1:0] du1;
        logic [DW-1:0] dv1;
        logic [DW-1:0] du2;
        logic [DW-1:0] dv2;
    } job_t;
endpackage
`default_nettype wire

// ----- src/tbt_fifo.sv -----
`default_nettype none
module tbt_fifo
    import tbt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  job_t      push_data,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output job_t      pop_data
);
    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push && !full) begin
                mem_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && not_empty) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'((push && !full) ? 1 : 0)
                                   - 2'((pop && not_empty) ? 1 : 0);
        end
    end
endmodule
`default_nettype wire

// ----- src/tbt_front.sv -----
`default_nettype none
module tbt_front
    import tbt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_pos_x,
    input  wire logic [31:0] s_pos_y,
    input  wire logic [31:0] s_pos_z,
    input  wire logic [31:0] s_tex_u,
    input  wire logic [31:0] s_tex_v,
    input  wire logic        s_end_of_mesh,
    output logic             job_push,
    output job_t             job_data,
    input  wire logic        job_full
);
    logic [1:0]       phase_reg;
    logic [2:0][31:0] pos0_reg;
    logic [2:0][31:0] pos1_reg;
    logic [31:0]      u0_reg, v0_reg, u1_reg, v1_reg;
    logic [2:0][31:0] pin;
    logic             take;

    function automatic logic [DW-1:0] sdiff(input logic [31:0] a, input logic [31:0] b);
        sdiff = {a[31], a} - {b[31], b};
    endfunction

    assign pin     = {s_pos_z, s_pos_y, s_pos_x};
    assign s_ready = (phase_reg != 2'd2) || !job_full;
    assign take    = s_valid && s_ready;
    assign job_push = take && (phase_reg == 2'd2);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            job_data.dp1[c] = sdiff(pos1_reg[c], pos0_reg[c]);
            job_data.dp2[c] = sdiff(pin[c], pos0_reg[c]);
        end
        job_data.du1 = sdiff(u1_reg, u0_reg);
        job_data.dv1 = sdiff(v1_reg, v0_reg);
        job_data.du2 = sdiff(s_tex_u, u0_reg);
        job_data.dv2 = sdiff(s_tex_v, v0_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 2'd0;
        end else if (take) begin
            if (phase_reg == 2'd0) begin
                pos0_reg <= pin;
                u0_reg   <= s_tex_u;
                v0_reg   <= s_tex_v;
            end
            if (phase_reg == 2'd1) begin
                pos1_reg <= pin;
                u1_reg   <= s_tex_u;
                v1_reg   <= s_tex_v;
            end
            // end of mesh drops a partial triangle
            if (phase_reg == 2'd2 || s_end_of_mesh) begin
                phase_reg <= 2'd0;
            end else begin
                phase_reg <= phase_reg + 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/tbt_back.sv -----
`default_nettype none
module tbt_back
    import tbt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        job_valid,
    output logic             job_pop,
    input  job_t             job_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_tangent_x,
    output logic [31:0]      m_tangent_y,
    output logic [31:0]      m_tangent_z,
    output logic [31:0]      m_bitangent_x,
    output logic [31:0]      m_bitangent_y,
    output logic [31:0]      m_bitangent_z,
    output logic [1:0]       m_vertex_slot,
    output logic             m_degenerate,
    output logic             m_saturated,
    output logic             m_last_of_run
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_CHECK, S_DIV_SETUP, S_DIV, S_DIV_DONE, S_EMIT
    } state_t;

    state_t                state_reg;
    job_t                  job_reg;
    logic [3:0]            step_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [PW-1:0]  acc_reg;
    logic signed [CW-1:0]  cross_reg [NCROSS];
    logic [2:0]            idx_reg;
    logic [3:0]            cnt_reg;
    logic [MW-1:0]         rem_reg;
    logic [MW-1:0]         den_reg;
    logic [QW-1:0]         sh_reg;
    logic [QW-1:0]         q_reg;
    logic                  neg_reg;
    logic [31:0]           vec_reg [6];
    logic                  sat_reg;
    logic                  degen_reg;
    logic [1:0]            copy_reg;
    logic                  m_valid_reg;
    logic [31:0]           out_reg [6];
    logic [1:0]            slot_reg;
    logic                  odegen_reg, osat_reg, olast_reg;

    logic [DW-1:0]         op_a, op_b;
    logic signed [CW-1:0]  num, den;
    logic [MW-1:0]         nmag, dmag;
    logic [NW-1:0]         nsh;
    logic                  ovf;
    logic [MW-1:0]         rem_a, rem_b;
    logic                  qb_a, qb_b;
    logic [2:0]            pidx;
    logic [2:0]            xidx;

    // operand pair for each multiply step
    always_comb begin
        logic [2:0] k;
        logic [1:0] c;
        k = 3'(step_reg >> 1);
        c = 2'd0;
        op_a = job_reg.du1;
        op_b = job_reg.dv2;
        case (k)
            3'd1, 3'd2, 3'd3: begin
                c = 2'(k - 3'd1);
                op_a = step_reg[0] ? job_reg.dp2[c] : job_reg.dp1[c];
                op_b = step_reg[0] ? job_reg.dv1 : job_reg.dv2;
            end
            3'd4, 3'd5, 3'd6: begin
                c = 2'(k - 3'd4);
                op_a = step_reg[0] ? job_reg.dp1[c] : job_reg.dp2[c];
                op_b = step_reg[0] ? job_reg.du2 : job_reg.du1;
            end
            default: begin
                op_a = step_reg[0] ? job_reg.dv1 : job_reg.du1;
                op_b = step_reg[0] ? job_reg.du2 : job_reg.dv2;
            end
        endcase
    end

    function automatic logic [MW:0] div_step(input logic [MW-1:0] r, input logic b,
                                             input logic [MW-1:0] d);
        logic [MW:0] r2;
        r2 = {r, b};
        if (r2 >= {1'b0, d}) begin
            div_step = r2 - {1'b0, d};
        end else begin
            div_step = r2;
        end
    endfunction

    assign pidx = 3'(4'(step_reg - 4'd1) >> 1);
    assign xidx = idx_reg;

    always_comb begin
        logic [MW:0] s1, s2;
        num  = cross_reg[xidx];
        den  = cross_reg[0];
        nmag = MW'(num[CW-1] ? -num : num);
        dmag = MW'(den[CW-1] ? -den : den);
        nsh  = {nmag, {FRAC_BITS{1'b0}}};
        ovf  = CMPW'(nsh) >= {dmag, {QW{1'b0}}};
        // two quotient bits per cycle
        s1 = div_step(rem_reg, sh_reg[QW-1], den_reg);
        qb_a = s1 >= (MW+1)'(0) && ({rem_reg, sh_reg[QW-1]} >= {1'b0, den_reg});
        rem_a = s1[MW-1:0];
        s2 = div_step(rem_a, sh_reg[QW-2], den_reg);
        qb_b = {rem_a, sh_reg[QW-2]} >= {1'b0, den_reg};
        rem_b = s2[MW-1:0];
    end

    assign job_pop = (state_reg == S_IDLE) && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            step_reg    <= 4'd0;
            copy_reg    <= 2'd0;
        end else begin
            if (m_ready && state_reg != S_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        job_reg   <= job_data;
                        step_reg  <= 4'd0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (step_reg < 4'(NSTEP)) begin
                        prod_reg <= $signed(op_a) * $signed(op_b);
                    end
                    if (step_reg != 4'd0) begin
                        if (!step_reg[0]) begin
                            cross_reg[pidx] <= CW'(acc_reg) - CW'(prod_reg);
                        end else begin
                            acc_reg <= prod_reg;
                        end
                    end
                    if (step_reg == 4'(NSTEP)) begin
                        state_reg <= S_CHECK;
                    end
                    step_reg <= step_reg + 4'd1;
                end
                S_CHECK: begin
                    sat_reg <= 1'b0;
                    idx_reg <= 3'd1;
                    if (cross_reg[0] == '0) begin
                        degen_reg <= 1'b1;
                        for (int j = 0; j < 6; j++) vec_reg[j] <= 32'd0;
                        copy_reg  <= 2'd0;
                        state_reg <= S_EMIT;
                    end else begin
                        degen_reg <= 1'b0;
                        state_reg <= S_DIV_SETUP;
                    end
                end
                S_DIV_SETUP: begin
                    neg_reg <= num[CW-1] ^ den[CW-1];
                    den_reg <= dmag;
                    rem_reg <= MW'(nsh >> QW);
                    sh_reg  <= nsh[QW-1:0];
                    cnt_reg <= 4'd0;
                    q_reg   <= '0;
                    if (ovf) begin
                        sat_reg <= 1'b1;
                        vec_reg[3'(idx_reg - 3'd1)] <=
                            (num[CW-1] ^ den[CW-1]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        if (idx_reg == 3'd6) begin
                            copy_reg  <= 2'd0;
                            state_reg <= S_EMIT;
                        end else begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    rem_reg <= rem_b;
                    sh_reg  <= {sh_reg[QW-3:0], 2'b00};
                    q_reg   <= {q_reg[QW-3:0], qb_a, qb_b};
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) begin
                        state_reg <= S_DIV_DONE;
                    end
                end
                S_DIV_DONE: begin
                    if (!neg_reg) begin
                        if (q_reg > 32'h7FFF_FFFF) begin
                            sat_reg <= 1'b1;
                            vec_reg[3'(idx_reg - 3'd1)] <= 32'h7FFF_FFFF;
                        end else begin
                            vec_reg[3'(idx_reg - 3'd1)] <= q_reg;
                        end
                    end else begin
                        if (q_reg > 32'h8000_0000) begin
                            sat_reg <= 1'b1;
                            vec_reg[3'(idx_reg - 3'd1)] <= 32'h8000_0000;
                        end else begin
                            vec_reg[3'(idx_reg - 3'd1)] <= -q_reg;
                        end
                    end
                    if (idx_reg == 3'd6) begin
                        copy_reg  <= 2'd0;
                        state_reg <= S_EMIT;
                    end else begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= S_DIV_SETUP;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        for (int j = 0; j < 6; j++) out_reg[j] <= vec_reg[j];
                        slot_reg   <= copy_reg;
                        odegen_reg <= degen_reg;
                        osat_reg   <= sat_reg;
                        olast_reg  <= (copy_reg == 2'd2);
                        copy_reg   <= copy_reg + 2'd1;
                        if (copy_reg == 2'd2) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tangent_x   = out_reg[0];
    assign m_tangent_y   = out_reg[1];
    assign m_tangent_z   = out_reg[2];
    assign m_bitangent_x = out_reg[3];
    assign m_bitangent_y = out_reg[4];
    assign m_bitangent_z = out_reg[5];
    assign m_vertex_slot = slot_reg;
    assign m_degenerate  = odegen_reg;
    assign m_saturated   = osat_reg;
    assign m_last_of_run = olast_reg;
endmodule
`default_nettype wire

// ----- src/triangle_tangent_bitangent.sv -----
// triangle tangent / bitangent unit
// input channel s_*: one vertex word per handshake (position and uv, Q16.16,
// s_end_of_mesh on the last vertex of a list). output channel m_*: three words
// per triangle, one per vertex slot, carrying tangent, bitangent and flags.
// the first two vertices of a triangle are always accepted and held;
// the third is turned into edge deltas and queued (two triangles deep).
// the back end loads the job, runs one shared 33x33 multiplier over 14
// products, checks the uv determinant for zero, then runs six restoring
// divisions at two quotient bits a cycle (a division is skipped and the
// result saturated when the quotient overflows), then emits three words.
// a zero uv determinant skips the divisions and emits zero vectors.
// reset (aresetn low, synchronous) drops any partial triangle, empties the
// queue and clears the output valid flag.
// when m_ready is low the output word holds; the queue keeps accepting
// vertices until two triangles are waiting, then s_ready drops on third vertices.
`default_nettype none
`include "triangle_tangent_bitangent_assert.svh"
module triangle_tangent_bitangent
    import tbt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_pos_x,
    input  wire logic [31:0] s_pos_y,
    input  wire logic [31:0] s_pos_z,
    input  wire logic [31:0] s_tex_u,
    input  wire logic [31:0] s_tex_v,
    input  wire logic        s_end_of_mesh,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_tangent_x,
    output logic [31:0]      m_tangent_y,
    output logic [31:0]      m_tangent_z,
    output logic [31:0]      m_bitangent_x,
    output logic [31:0]      m_bitangent_y,
    output logic [31:0]      m_bitangent_z,
    output logic [1:0]       m_vertex_slot,
    output logic             m_degenerate,
    output logic             m_saturated,
    output logic             m_last_of_run
);
    logic job_push, job_full, job_pop, job_valid;
    job_t push_data, pop_data;

    tbt_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready,
        .s_pos_x, .s_pos_y, .s_pos_z, .s_tex_u, .s_tex_v, .s_end_of_mesh,
        .job_push, .job_data(push_data), .job_full
    );

    tbt_fifo u_fifo (
        .aclk, .aresetn,
        .push(job_push), .push_data, .full(job_full),
        .pop(job_pop), .not_empty(job_valid), .pop_data
    );

    tbt_back u_back (
        .aclk, .aresetn, .job_valid, .job_pop, .job_data(pop_data),
        .m_valid, .m_ready,
        .m_tangent_x, .m_tangent_y, .m_tangent_z,
        .m_bitangent_x, .m_bitangent_y, .m_bitangent_z,
        .m_vertex_slot, .m_degenerate, .m_saturated, .m_last_of_run
    );

    `TBT_ASSERT_NOW(a_degen_zero, aclk, aresetn, m_valid && m_degenerate,
        !m_saturated && m_tangent_x == 32'd0 && m_bitangent_z == 32'd0)
    `TBT_ASSERT_NOW(a_last_slot, aclk, aresetn, m_valid,
        m_last_of_run == (m_vertex_slot == 2'd2))
    `TBT_ASSERT_NEXT(a_copies_follow, aclk, aresetn, m_valid && m_ready && !m_last_of_run,
        m_valid && m_vertex_slot == $past(m_vertex_slot) + 2'd1)
endmodule
`default_nettype wire

// ----- bench/tb_triangle_tangent_bitangent.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_triangle_tangent_bitangent;

    typedef struct {
        logic [31:0] px, py, pz, tu, tv;
        logic        eom;
    } vertex_t;

    typedef struct {
        logic [31:0] tan_x, tan_y, tan_z, bit_x, bit_y, bit_z;
        logic [1:0]  slot;
        logic        degen, sat, last;
    } frame_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_pos_x, s_pos_y, s_pos_z, s_tex_u, s_tex_v;
    logic        s_end_of_mesh;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_tangent_x, m_tangent_y, m_tangent_z;
    logic [31:0] m_bitangent_x, m_bitangent_y, m_bitangent_z;
    logic [1:0]  m_vertex_slot;
    logic        m_degenerate, m_saturated, m_last_of_run;

    vertex_t vertex_q[$];
    frame_t  frame_q[$];
    int      err_cnt = 0;
    int      gap_cnt = 0;
    int      hold_off = 0;
    bit      hold_req = 0;
    bit      hold_done = 0;

    // predictor copy of the held triangle corner data
    logic [31:0] pos_hold[6];
    logic [31:0] uv_hold[4];
    int          corner_cnt = 0;

    triangle_tangent_bitangent dut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] div_sat(input logic signed [127:0] num,
                                            input logic signed [127:0] den,
                                            inout bit sat);
        logic signed [127:0] q;
        q = (num * 128'sd65536) / den;
        if (q > 128'sh7FFFFFFF) begin
            sat = 1;
            return 32'h7FFFFFFF;
        end
        if (q < -128'sh80000000) begin
            sat = 1;
            return 32'h80000000;
        end
        return q[31:0];
    endfunction

    function automatic logic signed [127:0] sx(input logic [31:0] v);
        return {{96{v[31]}}, v};
    endfunction

    task automatic predict_vertex(input vertex_t v);
        logic signed [127:0] dp1[3], dp2[3], pin[3];
        logic signed [127:0] du1, dv1, du2, dv2, det;
        logic [31:0] vec[6];
        bit sat;
        frame_t f;
        sat = 0;
        if (corner_cnt < 2) begin
            pos_hold[corner_cnt*3]   = v.px;
            pos_hold[corner_cnt*3+1] = v.py;
            pos_hold[corner_cnt*3+2] = v.pz;
            uv_hold[corner_cnt*2]    = v.tu;
            uv_hold[corner_cnt*2+1]  = v.tv;
            corner_cnt = v.eom ? 0 : corner_cnt + 1;
            return;
        end
        pin[0] = sx(v.px);
        pin[1] = sx(v.py);
        pin[2] = sx(v.pz);
        for (int c = 0; c < 3; c++) begin
            dp1[c] = sx(pos_hold[3+c]) - sx(pos_hold[c]);
            dp2[c] = pin[c] - sx(pos_hold[c]);
        end
        du1 = sx(uv_hold[2]) - sx(uv_hold[0]);
        dv1 = sx(uv_hold[3]) - sx(uv_hold[1]);
        du2 = sx(v.tu) - sx(uv_hold[0]);
        dv2 = sx(v.tv) - sx(uv_hold[1]);
        det = du1 * dv2 - dv1 * du2;
        for (int c = 0; c < 3; c++) begin
            if (det == 0) begin
                vec[c] = '0;
                vec[3+c] = '0;
            end else begin
                vec[c]   = div_sat(dp1[c] * dv2 - dp2[c] * dv1, det, sat);
                vec[3+c] = div_sat(dp2[c] * du1 - dp1[c] * du2, det, sat);
            end
        end
        for (int k = 0; k < 3; k++) begin
            f.tan_x = vec[0]; f.tan_y = vec[1]; f.tan_z = vec[2];
            f.bit_x = vec[3]; f.bit_y = vec[4]; f.bit_z = vec[5];
            f.slot  = k[1:0];
            f.degen = (det == 0);
            f.sat   = sat;
            f.last  = (k == 2);
            frame_q.push_back(f);
        end
        corner_cnt = 0;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_cnt > 0 || vertex_q.size() == 0) begin
                if (gap_cnt > 0) gap_cnt <= gap_cnt - 1;
                s_valid <= 1'b0;
            end else begin
                vertex_t v;
                v = vertex_q.pop_front();
                s_pos_x <= v.px; s_pos_y <= v.py; s_pos_z <= v.pz;
                s_tex_u <= v.tu; s_tex_v <= v.tv; s_end_of_mesh <= v.eom;
                s_valid <= 1'b1;
                gap_cnt <= pick_gap();
            end
        end
    end

    // input word accepted: feed the predictor
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            vertex_t v;
            v.px = s_pos_x; v.py = s_pos_y; v.pz = s_pos_z;
            v.tu = s_tex_u; v.tv = s_tex_v; v.eom = s_end_of_mesh;
            predict_vertex(v);
        end
    end

    // result check
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_q.size() == 0) begin
                report("unexpected word", m_tangent_x, 32'h0);
            end else begin
                frame_t f;
                f = frame_q.pop_front();
                if (m_tangent_x !== f.tan_x) report("tangent_x", m_tangent_x, f.tan_x);
                if (m_tangent_y !== f.tan_y) report("tangent_y", m_tangent_y, f.tan_y);
                if (m_tangent_z !== f.tan_z) report("tangent_z", m_tangent_z, f.tan_z);
                if (m_bitangent_x !== f.bit_x)
                    report("bitangent_x", m_bitangent_x, f.bit_x);
                if (m_bitangent_y !== f.bit_y)
                    report("bitangent_y", m_bitangent_y, f.bit_y);
                if (m_bitangent_z !== f.bit_z)
                    report("bitangent_z", m_bitangent_z, f.bit_z);
                if (m_vertex_slot !== f.slot)
                    report("vertex_slot", 32'(m_vertex_slot), 32'(f.slot));
                if (m_degenerate !== f.degen)
                    report("degenerate", 32'(m_degenerate), 32'(f.degen));
                if (m_saturated !== f.sat)
                    report("saturated", 32'(m_saturated), 32'(f.sat));
                if (m_last_of_run !== f.last)
                    report("last_of_run", 32'(m_last_of_run), 32'(f.last));
            end
        end
    end

    // receiver stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_off <= 700;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    function automatic logic [31:0] near(input logic [31:0] base, input int span);
        return base + $urandom_range(0, 2 * span) - span;
    endfunction

    task automatic push_vertex(input logic [31:0] px, py, pz, tu, tv, input logic eom);
        vertex_t v;
        v.px = px; v.py = py; v.pz = pz; v.tu = tu; v.tv = tv; v.eom = eom;
        vertex_q.push_back(v);
    endtask

    // one triangle with random content; style picks how wild the values are
    task automatic push_random_triangle();
        logic [31:0] p[3][3], t[3][2];
        int style, drop_at;
        style = $urandom_range(0, 9);
        drop_at = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 1) : 3;
        for (int k = 0; k < 3; k++)
            for (int c = 0; c < 3; c++) p[k][c] = $urandom;
        for (int k = 0; k < 3; k++) begin
            t[k][0] = $urandom;
            t[k][1] = $urandom;
        end
        if (style < 6) begin
            // local triangle: small edges, well conditioned
            for (int k = 1; k < 3; k++) begin
                for (int c = 0; c < 3; c++) p[k][c] = near(p[0][c], 1 << 20);
                t[k][0] = near(t[0][0], 1 << 17);
                t[k][1] = near(t[0][1], 1 << 17);
            end
        end else if (style < 8) begin
            // tiny uv span so quotients overflow
            for (int k = 1; k < 3; k++) begin
                t[k][0] = near(t[0][0], 3);
                t[k][1] = near(t[0][1], 3);
            end
        end else if (style == 8) begin
            // collinear uv: zero determinant
            t[2][0] = t[0][0];
            t[2][1] = t[0][1];
        end
        for (int k = 0; k < 3; k++) begin
            push_vertex(p[k][0], p[k][1], p[k][2], t[k][0], t[k][1],
                        k == drop_at || (k == 2 && $urandom_range(0, 3) == 0));
            if (k == drop_at) break;
        end
    endtask

    task automatic wait_drained();
        while (vertex_q.size() != 0 || s_valid || frame_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: unit triangle
        push_vertex(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        push_vertex(32'h10000, 32'h0, 32'h0, 32'h10000, 32'h0, 1'b0);
        push_vertex(32'h0, 32'h10000, 32'h0, 32'h0, 32'h10000, 1'b1);
        // extremes of position and uv
        push_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1'b0);
        push_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0);
        push_vertex(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
        // zero determinant
        push_vertex(32'h1, 32'h2, 32'h3, 32'h5000, 32'h6000, 1'b0);
        push_vertex(32'h7, 32'h8, 32'h9, 32'h5000, 32'h6000, 1'b0);
        push_vertex(32'hFFFFFFFF, 32'h0, 32'h1, 32'h9000, 32'h1000, 1'b0);
        // tiny determinant, huge edges: clamp both ways
        push_vertex(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        push_vertex(32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h1, 32'h0, 1'b0);
        push_vertex(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h1, 1'b0);
        // mesh end on first vertex, then on second, each drops the partial triangle
        push_vertex(32'h12345678, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        push_vertex(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        push_vertex(32'hDEADBEEF, 32'h1, 32'h2, 32'h3, 32'h4, 1'b1);
        push_vertex(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        push_vertex(32'h20000, 32'h0, 32'h0, 32'h0, 32'h20000, 1'b0);
        push_vertex(32'h0, 32'h30000, 32'hFFFF0000, 32'hFFFF0000, 32'h0, 1'b1);

        // the test waits for every result before the random part
        wait_drained();

        while (vertex_q.size() < 120) push_random_triangle();
        hold_req = 1'b1;
        while (vertex_q.size() < 250) push_random_triangle();
        wait_drained();
        repeat (300) @(posedge aclk);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
